// File: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Geometry constants, field widths, command codes and the types shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int CELLS     = ROWS * COLUMNS;

   localparam int ROW_W     = $clog2(ROWS + 1);
   localparam int ROW_IDX_W = $clog2(ROWS);
   localparam int COL_IDX_W = $clog2(COLUMNS);
   localparam int LEN_W     = $clog2(COLUMNS + 1);
   localparam int ADDR_W    = $clog2(CELLS);

   localparam int CMD_W     = 3;
   localparam int CHAR_W    = 8;
   localparam int DELTA_W   = 6;
   localparam int RD_ROW_W  = 5;
   localparam int RD_COL_W  = 7;
   localparam int OUT_ROW_W = 5;
   localparam int OUT_COL_W = 7;
   localparam int CELL_W    = 16;
   localparam int TGT_W     = ROW_W + DELTA_W;

   localparam logic [7:0] TEXT_ATTR = 8'h0F;
   localparam logic [7:0] NEWLINE   = 8'h0A;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT       = 3'd0,
      CMD_BACKSPACE = 3'd1,
      CMD_CLEAR     = 3'd2,
      CMD_MOVE      = 3'd3,
      CMD_READ      = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_SCROLL,
      ST_PUT,
      ST_BS_LOOK,
      ST_BS_PREV,
      ST_BS_ERASE,
      ST_CLEAR,
      ST_MOVE_ROW,
      ST_MOVE_COL,
      ST_READ_ISSUE,
      ST_READ_TAKE,
      ST_RESPOND
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_INIT_SWEEP,
      DP_CLEAR_SWEEP,
      DP_SCROLL_SWEEP,
      DP_PUT,
      DP_BS_LOOK,
      DP_BS_PREV,
      DP_BS_ERASE,
      DP_MOVE_ROW,
      DP_MOVE_COL,
      DP_READ_ISSUE,
      DP_READ_TAKE,
      DP_RESPOND
   } dp_op_type;

   typedef struct packed {
      cmd_type cmd;
      logic    char_zero;
      logic    char_newline;
      logic    cursor_past;
      logic    cursor_zero;
      logic    next_row_past;
      logic    delta_zero;
      logic    read_in_range;
      logic    sweep_row_last;
      logic    sweep_all_last;
      logic    out_free;
   } dp_status_type;

endpackage

// File: rtl/core/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences each command through the datapath, one operation per cycle.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcw_pkg::dp_status_type status,
   output tcw_pkg::dp_op_type     op
);

   tcw_pkg::state_type state_ff, state_in;
   logic               put_done_ff, put_done_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_INIT: begin
            if (status.sweep_all_last) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tcw_pkg::ST_DECODE;
            end
         end
         tcw_pkg::ST_DECODE: begin
            unique case (status.cmd)
               tcw_pkg::CMD_PUT: begin
                  if (status.char_zero) begin
                     state_in = tcw_pkg::ST_RESPOND;
                  end else if (status.cursor_past) begin
                     state_in = tcw_pkg::ST_SCROLL;
                  end else begin
                     state_in = tcw_pkg::ST_PUT;
                  end
               end
               tcw_pkg::CMD_BACKSPACE: begin
                  state_in = status.cursor_zero ? tcw_pkg::ST_RESPOND : tcw_pkg::ST_BS_LOOK;
               end
               tcw_pkg::CMD_CLEAR: begin
                  state_in = tcw_pkg::ST_CLEAR;
               end
               tcw_pkg::CMD_MOVE: begin
                  state_in = status.delta_zero ? tcw_pkg::ST_RESPOND : tcw_pkg::ST_MOVE_ROW;
               end
               tcw_pkg::CMD_READ: begin
                  state_in = status.read_in_range ? tcw_pkg::ST_READ_ISSUE
                                                  : tcw_pkg::ST_RESPOND;
               end
               default: begin
                  state_in = tcw_pkg::ST_RESPOND;
               end
            endcase
         end
         tcw_pkg::ST_SCROLL: begin
            if (status.sweep_row_last) begin
               state_in = put_done_ff ? tcw_pkg::ST_RESPOND : tcw_pkg::ST_PUT;
            end
         end
         tcw_pkg::ST_PUT: begin
            if (status.char_newline && status.next_row_past) begin
               state_in = tcw_pkg::ST_SCROLL;
            end else begin
               state_in = tcw_pkg::ST_RESPOND;
            end
         end
         tcw_pkg::ST_BS_LOOK:    state_in = tcw_pkg::ST_BS_PREV;
         tcw_pkg::ST_BS_PREV:    state_in = tcw_pkg::ST_BS_ERASE;
         tcw_pkg::ST_BS_ERASE:   state_in = tcw_pkg::ST_RESPOND;
         tcw_pkg::ST_CLEAR: begin
            if (status.sweep_all_last) begin
               state_in = tcw_pkg::ST_RESPOND;
            end
         end
         tcw_pkg::ST_MOVE_ROW:   state_in = tcw_pkg::ST_MOVE_COL;
         tcw_pkg::ST_MOVE_COL:   state_in = tcw_pkg::ST_RESPOND;
         tcw_pkg::ST_READ_ISSUE: state_in = tcw_pkg::ST_READ_TAKE;
         tcw_pkg::ST_READ_TAKE:  state_in = tcw_pkg::ST_RESPOND;
         tcw_pkg::ST_RESPOND: begin
            if (status.out_free) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_INIT;
         end
      endcase
   end

   always_comb begin
      op          = tcw_pkg::DP_NOP;
      put_done_in = put_done_ff;
      unique case (state_ff)
         tcw_pkg::ST_INIT:       op = tcw_pkg::DP_INIT_SWEEP;
         tcw_pkg::ST_IDLE: begin
            if (req_valid) begin
               op          = tcw_pkg::DP_CAPTURE;
               put_done_in = 1'b0;
            end
         end
         tcw_pkg::ST_DECODE:     op = tcw_pkg::DP_NOP;
         tcw_pkg::ST_SCROLL:     op = tcw_pkg::DP_SCROLL_SWEEP;
         tcw_pkg::ST_PUT: begin
            op          = tcw_pkg::DP_PUT;
            put_done_in = 1'b1;
         end
         tcw_pkg::ST_BS_LOOK:    op = tcw_pkg::DP_BS_LOOK;
         tcw_pkg::ST_BS_PREV:    op = tcw_pkg::DP_BS_PREV;
         tcw_pkg::ST_BS_ERASE:   op = tcw_pkg::DP_BS_ERASE;
         tcw_pkg::ST_CLEAR:      op = tcw_pkg::DP_CLEAR_SWEEP;
         tcw_pkg::ST_MOVE_ROW:   op = tcw_pkg::DP_MOVE_ROW;
         tcw_pkg::ST_MOVE_COL:   op = tcw_pkg::DP_MOVE_COL;
         tcw_pkg::ST_READ_ISSUE: op = tcw_pkg::DP_READ_ISSUE;
         tcw_pkg::ST_READ_TAKE:  op = tcw_pkg::DP_READ_TAKE;
         tcw_pkg::ST_RESPOND:    op = tcw_pkg::DP_RESPOND;
         default:                op = tcw_pkg::DP_NOP;
      endcase
   end

   assign req_stall = (state_ff != tcw_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tcw_pkg::ST_INIT;
         put_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         put_done_ff <= put_done_in;
      end
   end

endmodule

// File: rtl/core/tcw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer datapath
// Cell store with a ring top-row pointer, cursor, row lengths, request
// capture and the result register.
// ----------------------------------------------------------------------------
module tcw_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tcw_pkg::dp_op_type                   op,
   output tcw_pkg::dp_status_type               status,
   input  logic [tcw_pkg::CMD_W-1:0]            req_cmd,
   input  logic [tcw_pkg::CHAR_W-1:0]           req_char_code,
   input  logic signed [tcw_pkg::DELTA_W-1:0]   req_row_delta,
   input  logic [tcw_pkg::RD_ROW_W-1:0]         req_read_row,
   input  logic [tcw_pkg::RD_COL_W-1:0]         req_read_col,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tcw_pkg::OUT_ROW_W-1:0]        rsp_cursor_row,
   output logic [tcw_pkg::OUT_COL_W-1:0]        rsp_cursor_col,
   output logic [7:0]                           rsp_cell_char,
   output logic [7:0]                           rsp_cell_attr,
   output logic                                 rsp_scrolled
);

   localparam int ROWS      = tcw_pkg::ROWS;
   localparam int COLUMNS   = tcw_pkg::COLUMNS;
   localparam int ROW_W     = tcw_pkg::ROW_W;
   localparam int ROW_IDX_W = tcw_pkg::ROW_IDX_W;
   localparam int COL_IDX_W = tcw_pkg::COL_IDX_W;
   localparam int LEN_W     = tcw_pkg::LEN_W;
   localparam int ADDR_W    = tcw_pkg::ADDR_W;
   localparam int TGT_W     = tcw_pkg::TGT_W;

   function automatic logic [ROW_IDX_W-1:0] phys_row(input logic [ROW_IDX_W-1:0] lrow,
                                                     input logic [ROW_IDX_W-1:0] top);
      logic [ROW_IDX_W:0] sum;
      sum = {1'b0, lrow} + {1'b0, top};
      if (sum >= (ROW_IDX_W + 1)'(ROWS)) begin
         sum = sum - (ROW_IDX_W + 1)'(ROWS);
      end
      return sum[ROW_IDX_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_IDX_W-1:0] prow,
                                                   input logic [COL_IDX_W-1:0] col);
      return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

   logic [ROW_W-1:0]                  row_ff, row_in;
   logic [LEN_W-1:0]                  col_ff, col_in;
   logic [ROW_IDX_W-1:0]              top_ff, top_in;
   logic [LEN_W-1:0]                  len_ff [ROWS];
   logic [LEN_W-1:0]                  len_in [ROWS];
   logic [ADDR_W-1:0]                 cnt_ff, cnt_in;
   logic                              take_prev_ff, take_prev_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic [tcw_pkg::CMD_W-1:0]         cmd_ff, cmd_in;
   logic [tcw_pkg::CHAR_W-1:0]        char_ff, char_in;
   logic signed [tcw_pkg::DELTA_W-1:0] delta_ff, delta_in;
   logic [tcw_pkg::RD_ROW_W-1:0]      rrow_ff, rrow_in;
   logic [tcw_pkg::RD_COL_W-1:0]      rcol_ff, rcol_in;
   logic [7:0]                        cell_char_ff, cell_char_in;
   logic [7:0]                        cell_attr_ff, cell_attr_in;
   logic                              scr_ff, scr_in;
   logic [tcw_pkg::OUT_ROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::OUT_COL_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [7:0]                        rsp_char_ff, rsp_char_in;
   logic [7:0]                        rsp_attr_ff, rsp_attr_in;
   logic                              rsp_scr_ff, rsp_scr_in;

   logic [tcw_pkg::CELL_W-1:0]        mem [tcw_pkg::CELLS];
   logic [tcw_pkg::CELL_W-1:0]        rd_data_ff;
   logic                              mem_we;
   logic [ADDR_W-1:0]                 mem_addr;
   logic [tcw_pkg::CELL_W-1:0]        mem_wdata;

   logic                              row_on_screen;
   logic [ROW_IDX_W-1:0]              cur_prow;
   logic [LEN_W-1:0]                  len_cur;
   logic [LEN_W-1:0]                  erase_col;
   logic signed [TGT_W-1:0]           target;
   logic [LEN_W-1:0]                  move_col;
   logic                              out_free;

   assign row_on_screen = (row_ff < ROW_W'(ROWS));
   assign cur_prow      = phys_row(row_ff[ROW_IDX_W-1:0], top_ff);
   assign len_cur       = row_on_screen ? len_ff[row_ff[ROW_IDX_W-1:0]] : '0;
   assign erase_col     = (col_ff == '0) ? '0 : col_ff - LEN_W'(1);
   assign target        = $signed({{tcw_pkg::DELTA_W{1'b0}}, row_ff}) - TGT_W'(delta_ff);
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      move_col = col_ff;
      if (len_cur <= col_ff) begin
         move_col = len_cur;
      end
      if (move_col > LEN_W'(COLUMNS - 1)) begin
         move_col = LEN_W'(COLUMNS - 1);
      end
   end

   always_comb begin
      status.cmd            = tcw_pkg::cmd_type'(cmd_ff);
      status.char_zero      = (char_ff == '0);
      status.char_newline   = (char_ff == tcw_pkg::NEWLINE);
      status.cursor_past    = (row_ff == ROW_W'(ROWS));
      status.cursor_zero    = (row_ff == '0) && (col_ff == '0);
      status.next_row_past  = (int'(row_ff) + 1 >= ROWS);
      status.delta_zero     = (delta_ff == '0);
      status.read_in_range  = (int'(rrow_ff) < ROWS) && (int'(rcol_ff) < COLUMNS);
      status.sweep_row_last = (cnt_ff == ADDR_W'(COLUMNS - 1));
      status.sweep_all_last = (cnt_ff == ADDR_W'(tcw_pkg::CELLS - 1));
      status.out_free       = out_free;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = cell_addr(cur_prow, col_ff[COL_IDX_W-1:0]);
      mem_wdata = '0;
      case (op)
         tcw_pkg::DP_INIT_SWEEP: begin
            mem_we   = 1'b1;
            mem_addr = cnt_ff;
         end
         tcw_pkg::DP_CLEAR_SWEEP: begin
            mem_we    = 1'b1;
            mem_addr  = cnt_ff;
            mem_wdata = {tcw_pkg::TEXT_ATTR, 8'h00};
         end
         tcw_pkg::DP_SCROLL_SWEEP: begin
            mem_we   = 1'b1;
            mem_addr = cell_addr(top_ff, cnt_ff[COL_IDX_W-1:0]);
         end
         tcw_pkg::DP_PUT: begin
            mem_we    = (char_ff != tcw_pkg::NEWLINE) && row_on_screen;
            mem_wdata = {tcw_pkg::TEXT_ATTR, char_ff};
         end
         tcw_pkg::DP_BS_ERASE: begin
            mem_we    = row_on_screen;
            mem_addr  = cell_addr(cur_prow, erase_col[COL_IDX_W-1:0]);
            mem_wdata = {tcw_pkg::TEXT_ATTR, 8'h00};
         end
         tcw_pkg::DP_READ_ISSUE: begin
            mem_addr = cell_addr(phys_row(ROW_IDX_W'(rrow_ff), top_ff), COL_IDX_W'(rcol_ff));
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      top_in       = top_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      take_prev_in = take_prev_ff;
      cmd_in       = cmd_ff;
      char_in      = char_ff;
      delta_in     = delta_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      cell_char_in = cell_char_ff;
      cell_attr_in = cell_attr_ff;
      scr_in       = scr_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_scr_in   = rsp_scr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (op)
         tcw_pkg::DP_CAPTURE: begin
            cmd_in       = req_cmd;
            char_in      = req_char_code;
            delta_in     = req_row_delta;
            rrow_in      = req_read_row;
            rcol_in      = req_read_col;
            cell_char_in = '0;
            cell_attr_in = '0;
            scr_in       = 1'b0;
         end
         tcw_pkg::DP_INIT_SWEEP: begin
            cnt_in = status.sweep_all_last ? '0 : cnt_ff + ADDR_W'(1);
         end
         tcw_pkg::DP_CLEAR_SWEEP: begin
            cnt_in = status.sweep_all_last ? '0 : cnt_ff + ADDR_W'(1);
            if (status.sweep_all_last) begin
               row_in = '0;
               col_in = '0;
            end
         end
         tcw_pkg::DP_SCROLL_SWEEP: begin
            if (status.sweep_row_last) begin
               cnt_in = '0;
               top_in = (top_ff == ROW_IDX_W'(ROWS - 1)) ? '0 : top_ff + ROW_IDX_W'(1);
               for (int i = 0; i < ROWS - 1; i++) begin
                  len_in[i] = len_ff[i + 1];
               end
               len_in[ROWS - 1] = '0;
               row_in = ROW_W'(ROWS - 1);
               col_in = '0;
               scr_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         tcw_pkg::DP_PUT: begin
            if (row_on_screen && (len_cur < LEN_W'(COLUMNS))) begin
               len_in[row_ff[ROW_IDX_W-1:0]] = len_cur + LEN_W'(1);
            end
            if ((char_ff == tcw_pkg::NEWLINE) || (col_ff == LEN_W'(COLUMNS - 1))) begin
               row_in = row_ff + ROW_W'(1);
               col_in = '0;
            end else begin
               col_in = col_ff + LEN_W'(1);
            end
         end
         tcw_pkg::DP_BS_LOOK: begin
            take_prev_in = (len_cur == '0) && (row_ff != '0);
            if ((len_cur == '0) && (row_ff != '0)) begin
               row_in = row_ff - ROW_W'(1);
            end
         end
         tcw_pkg::DP_BS_PREV: begin
            if (take_prev_ff) begin
               col_in = len_cur;
            end
         end
         tcw_pkg::DP_BS_ERASE: begin
            col_in = erase_col;
            if ((col_ff != '0) && row_on_screen && (len_cur != '0)) begin
               len_in[row_ff[ROW_IDX_W-1:0]] = len_cur - LEN_W'(1);
            end
         end
         tcw_pkg::DP_MOVE_ROW: begin
            if (target < 0) begin
               row_in = '0;
            end else if (target > TGT_W'(ROWS - 1)) begin
               row_in = ROW_W'(ROWS - 1);
            end else begin
               row_in = target[ROW_W-1:0];
            end
         end
         tcw_pkg::DP_MOVE_COL: begin
            col_in = move_col;
         end
         tcw_pkg::DP_READ_TAKE: begin
            cell_char_in = rd_data_ff[7:0];
            cell_attr_in = rd_data_ff[15:8];
         end
         tcw_pkg::DP_RESPOND: begin
            if (out_free) begin
               rsp_row_in   = tcw_pkg::OUT_ROW_W'(row_ff);
               rsp_col_in   = tcw_pkg::OUT_COL_W'(col_ff);
               rsp_char_in  = cell_char_ff;
               rsp_attr_in  = cell_attr_ff;
               rsp_scr_in   = scr_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         cnt_ff       <= '0;
         take_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ROWS; i++) begin
            len_ff[i] <= '0;
         end
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         cnt_ff       <= cnt_in;
         take_prev_ff <= take_prev_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      char_ff      <= char_in;
      delta_ff     <= delta_in;
      rrow_ff      <= rrow_in;
      rcol_ff      <= rcol_in;
      cell_char_ff <= cell_char_in;
      cell_attr_ff <= cell_attr_in;
      scr_ff       <= scr_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_attr_ff  <= rsp_attr_in;
      rsp_scr_ff   <= rsp_scr_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;
   assign rsp_scrolled   = rsp_scr_ff;

endmodule

// File: rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// An 80x25 text console that executes one command per request beat and
// returns one result beat per command.
// ----------------------------------------------------------------------------
// Usage: the req channel carries a command with its character, row delta
// and read position; the rsp channel returns the cursor after the command,
// the read cell (zero for other commands) and a scroll flag. Both channels
// move a beat when valid is high and stall is low.
// One command is worked on at a time. Every scroll blanks the row that
// is freed one cell at a time, as the cell store has a single port and
// rows rotate through a top-row pointer. Clear screen makes one write per
// cell. A new request is taken in the cycle after the result is loaded.
// After reset the block zeroes all 2000 cells, one a cycle, and holds
// req_stall high while it does so. The result sits in an output register,
// so a stalled receiver only holds the following command at the point
// where its result would be loaded.
// ----------------------------------------------------------------------------
module text_console_writer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tcw_pkg::CMD_W-1:0]            req_cmd,
   input  logic [tcw_pkg::CHAR_W-1:0]           req_char_code,
   input  logic signed [tcw_pkg::DELTA_W-1:0]   req_row_delta,
   input  logic [tcw_pkg::RD_ROW_W-1:0]         req_read_row,
   input  logic [tcw_pkg::RD_COL_W-1:0]         req_read_col,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tcw_pkg::OUT_ROW_W-1:0]        rsp_cursor_row,
   output logic [tcw_pkg::OUT_COL_W-1:0]        rsp_cursor_col,
   output logic [7:0]                           rsp_cell_char,
   output logic [7:0]                           rsp_cell_attr,
   output logic                                 rsp_scrolled
);

   tcw_pkg::dp_op_type     op;
   tcw_pkg::dp_status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .op        (op)
   );

   tcw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .status         (status),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_row_delta  (req_row_delta),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_scrolled   (rsp_scrolled)
   );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives console commands into the block and checks every result beat
// against a cycle-free model of the screen, the row lengths and the cursor
// that is kept inside this bench. A short directed pass comes first. After
// it, backpressure on the result side fills the block and stalls requests.
// Then come three phases of random typing, reading, erasing, clears, cursor
// moves and reserved commands, with idle rates on the two channels that
// differ from phase to phase.
module tb_top;

   localparam int COLUMNS   = tcw_pkg::COLUMNS;
   localparam int ROWS      = tcw_pkg::ROWS;
   localparam int CELLS     = tcw_pkg::CELLS;
   localparam int CMD_W     = tcw_pkg::CMD_W;
   localparam int CHAR_W    = tcw_pkg::CHAR_W;
   localparam int DELTA_W   = tcw_pkg::DELTA_W;
   localparam int RD_ROW_W  = tcw_pkg::RD_ROW_W;
   localparam int RD_COL_W  = tcw_pkg::RD_COL_W;
   localparam int OUT_ROW_W = tcw_pkg::OUT_ROW_W;
   localparam int OUT_COL_W = tcw_pkg::OUT_COL_W;
   localparam int CELL_W    = tcw_pkg::CELL_W;

   localparam logic [7:0] TEXT_ATTR = tcw_pkg::TEXT_ATTR;
   localparam logic [7:0] NEWLINE   = tcw_pkg::NEWLINE;

   localparam logic [CMD_W-1:0] CMD_PUT       = tcw_pkg::CMD_PUT;
   localparam logic [CMD_W-1:0] CMD_BACKSPACE = tcw_pkg::CMD_BACKSPACE;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = tcw_pkg::CMD_CLEAR;
   localparam logic [CMD_W-1:0] CMD_MOVE      = tcw_pkg::CMD_MOVE;
   localparam logic [CMD_W-1:0] CMD_READ      = tcw_pkg::CMD_READ;

   localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;
   localparam int QUIET_LIMIT = 20000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic [7:0]           cell_char;
      logic [7:0]           cell_attr;
      logic                 scrolled;
   } cursor_report_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [CMD_W-1:0]           req_cmd;
   logic [CHAR_W-1:0]          req_char_code;
   logic signed [DELTA_W-1:0]  req_row_delta;
   logic [RD_ROW_W-1:0]        req_read_row;
   logic [RD_COL_W-1:0]        req_read_col;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [OUT_ROW_W-1:0]       rsp_cursor_row;
   logic [OUT_COL_W-1:0]       rsp_cursor_col;
   logic [7:0]                 rsp_cell_char;
   logic [7:0]                 rsp_cell_attr;
   logic                       rsp_scrolled;

   logic [CELL_W-1:0] screen_mirror [CELLS];
   int                line_len [ROWS];
   int                cursor_pos;

   cursor_report_type reports_due [$];
   int error_count = 0;
   int commands_applied = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_off_left = 0;
   int quiet_cycles = 0;

   text_console_writer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_row_delta  (req_row_delta),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_scrolled   (rsp_scrolled)
   );

   always #5 clock = ~clock;

   function automatic void scroll_mirror();
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
         screen_mirror[i] = screen_mirror[i + COLUMNS];
      end
      for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
         screen_mirror[i] = '0;
      end
      for (int r = 0; r < ROWS - 1; r++) begin
         line_len[r] = line_len[r + 1];
      end
      line_len[ROWS - 1] = 0;
      cursor_pos = (ROWS - 1) * COLUMNS;
   endfunction

   function automatic void lengthen_line(int r);
      if (r < ROWS && line_len[r] < COLUMNS) begin
         line_len[r]++;
      end
   endfunction

   function automatic void blank_cell_at(int idx);
      if (idx < CELLS) begin
         screen_mirror[idx] = {TEXT_ATTR, 8'h00};
      end
   endfunction

   function automatic cursor_report_type predict_report(logic [CMD_W-1:0] cmd,
                                                        logic [CHAR_W-1:0] ch,
                                                        logic signed [DELTA_W-1:0] delta,
                                                        logic [RD_ROW_W-1:0] rr,
                                                        logic [RD_COL_W-1:0] rc);
      cursor_report_type rep;
      int row;
      int col;
      int len;
      int target;
      int shift;
      rep = '0;
      row = cursor_pos / COLUMNS;
      col = cursor_pos % COLUMNS;
      shift = delta;
      case (cmd)
         CMD_PUT: begin
            if (ch != 8'h00) begin
               if (row >= ROWS) begin
                  scroll_mirror();
                  rep.scrolled = 1'b1;
                  row = ROWS - 1;
               end
               if (ch == NEWLINE) begin
                  lengthen_line(row);
                  cursor_pos = (row + 1) * COLUMNS;
                  if (row + 1 >= ROWS) begin
                     scroll_mirror();
                     rep.scrolled = 1'b1;
                  end
               end else begin
                  if (cursor_pos < CELLS) begin
                     screen_mirror[cursor_pos] = {TEXT_ATTR, ch};
                  end
                  cursor_pos++;
                  lengthen_line(row);
               end
            end
         end
         CMD_BACKSPACE: begin
            if (cursor_pos != 0) begin
               len = (row < ROWS) ? line_len[row] : 0;
               if (len == 0 && row > 0) begin
                  row--;
                  col = line_len[row];
               end
               if (col == 0) begin
                  cursor_pos = row * COLUMNS;
                  blank_cell_at(cursor_pos);
               end else begin
                  cursor_pos = row * COLUMNS + col - 1;
                  blank_cell_at(cursor_pos);
                  if (row < ROWS && line_len[row] > 0) begin
                     line_len[row]--;
                  end
               end
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < CELLS; i++) begin
               screen_mirror[i] = {TEXT_ATTR, 8'h00};
            end
            cursor_pos = 0;
         end
         CMD_MOVE: begin
            if (shift != 0) begin
               target = row - shift;
               if (target < 0) begin
                  target = 0;
               end
               if (target > ROWS - 1) begin
                  target = ROWS - 1;
               end
               len = line_len[target];
               if (len <= col) begin
                  col = len;
               end
               if (col > COLUMNS - 1) begin
                  col = COLUMNS - 1;
               end
               cursor_pos = target * COLUMNS + col;
            end
         end
         CMD_READ: begin
            if (rr < ROWS && rc < COLUMNS) begin
               rep.cell_char = screen_mirror[rr * COLUMNS + rc][7:0];
               rep.cell_attr = screen_mirror[rr * COLUMNS + rc][15:8];
            end
         end
         default: begin
         end
      endcase
      rep.row = OUT_ROW_W'(cursor_pos / COLUMNS);
      rep.col = OUT_COL_W'(cursor_pos % COLUMNS);
      return rep;
   endfunction

   task automatic send_command(input logic [CMD_W-1:0] cmd,
                               input logic [CHAR_W-1:0] ch,
                               input logic signed [DELTA_W-1:0] delta,
                               input logic [RD_ROW_W-1:0] rr,
                               input logic [RD_COL_W-1:0] rc);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_char_code <= ch;
      req_row_delta <= delta;
      req_read_row  <= rr;
      req_read_col  <= rc;
      forever begin
         @(posedge clock);
         if (!req_stall) begin
            break;
         end
      end
      reports_due.push_back(predict_report(cmd, ch, delta, rr, rc));
      if (!(cmd >= CMD_RESERVED_FIRST || (cmd == CMD_PUT && ch == 8'h00)
            || (cmd == CMD_MOVE && delta == 0))) begin
         commands_applied++;
      end
   endtask

   function automatic logic [CHAR_W-1:0] typed_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         return NEWLINE;
      end else if (pick < 10) begin
         return 8'h00;
      end
      return CHAR_W'($urandom_range(1, 255));
   endfunction

   task automatic test_directed_cases();
      send_command(CMD_READ, 8'h00, 0, 5'd0, 7'd0);
      send_command(CMD_READ, 8'h00, 0, 5'd31, 7'd127);
      send_command(CMD_READ, 8'h00, 0, 5'd24, 7'd80);
      send_command(CMD_PUT, 8'h00, 0, 5'd0, 7'd0);
      send_command(CMD_PUT, 8'h48, 0, 5'd0, 7'd0);
      send_command(CMD_PUT, 8'hFF, 0, 5'd0, 7'd0);
      send_command(CMD_PUT, 8'h01, 0, 5'd0, 7'd0);
      send_command(CMD_READ, 8'h00, 0, 5'd0, 7'd1);
      send_command(CMD_PUT, NEWLINE, 0, 5'd0, 7'd0);
      send_command(CMD_BACKSPACE, 8'h00, 0, 5'd0, 7'd0);
      send_command(CMD_BACKSPACE, 8'h00, 0, 5'd0, 7'd0);
      send_command(CMD_MOVE, 8'h00, 0, 5'd0, 7'd0);
      send_command(CMD_MOVE, 8'h00, -25, 5'd0, 7'd0);
      send_command(CMD_MOVE, 8'h00, -32, 5'd0, 7'd0);
      send_command(CMD_MOVE, 8'h00, 25, 5'd0, 7'd0);
      send_command(CMD_MOVE, 8'h00, 31, 5'd0, 7'd0);
      send_command(CMD_BACKSPACE, 8'h00, 0, 5'd0, 7'd0);
      send_command(CMD_RESERVED_FIRST, 8'hFF, -1, 5'd31, 7'd127);
      send_command(CMD_RESERVED_LAST, 8'hFF, -1, 5'd31, 7'd127);
      send_command(CMD_CLEAR, 8'h00, 0, 5'd0, 7'd0);
      send_command(CMD_READ, 8'h00, 0, 5'd0, 7'd0);
      send_command(CMD_MOVE, 8'h00, -25, 5'd0, 7'd0);
      send_command(CMD_PUT, 8'h5A, 0, 5'd0, 7'd0);
      send_command(CMD_PUT, NEWLINE, 0, 5'd0, 7'd0);
      send_command(CMD_BACKSPACE, 8'h00, 0, 5'd0, 7'd0);
   endtask

   task automatic test_output_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      @(negedge clock);
      hold_off_left = 400;
      repeat (16) begin
         send_command(CMD_PUT, typed_char(), DELTA_W'($urandom), RD_ROW_W'($urandom),
                      RD_COL_W'($urandom));
      end
   endtask

   task automatic test_console_traffic(input int goal, input int tx_pct, input int rx_pct);
      int target;
      int kind;
      int count;
      int shift;
      int row_now;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      target = commands_applied + goal;
      while (commands_applied < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            count = $urandom_range(0, 9);
            if (count < 5) begin
               count = $urandom_range(1, 40);
            end else if (count < 8) begin
               count = COLUMNS - cursor_pos % COLUMNS + $urandom_range(0, 2);
            end else begin
               count = $urandom_range(41, 120);
            end
            repeat (count) begin
               send_command(CMD_PUT, typed_char(), DELTA_W'($urandom), RD_ROW_W'($urandom),
                            RD_COL_W'($urandom));
            end
         end else if (kind < 70) begin
            repeat ($urandom_range(1, 6)) begin
               row_now = cursor_pos / COLUMNS;
               if ($urandom_range(0, 3) == 0) begin
                  send_command(CMD_READ, CHAR_W'($urandom), DELTA_W'($urandom),
                               RD_ROW_W'($urandom_range(0, 31)),
                               RD_COL_W'($urandom_range(0, 127)));
               end else begin
                  send_command(CMD_READ, CHAR_W'($urandom), DELTA_W'($urandom),
                               RD_ROW_W'((row_now >= 2) ? row_now - $urandom_range(0, 2)
                                                        : row_now),
                               RD_COL_W'($urandom_range(0, COLUMNS - 1)));
               end
            end
         end else if (kind < 82) begin
            repeat ($urandom_range(1, 12)) begin
               send_command(CMD_BACKSPACE, CHAR_W'($urandom), DELTA_W'($urandom),
                            RD_ROW_W'($urandom), RD_COL_W'($urandom));
            end
         end else if (kind < 94) begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 4) == 0) begin
                  shift = $urandom_range(0, 63);
               end else begin
                  shift = $urandom_range(0, 50) - 25;
               end
               send_command(CMD_MOVE, CHAR_W'($urandom), DELTA_W'(shift),
                            RD_ROW_W'($urandom), RD_COL_W'($urandom));
            end
         end else if (kind < 97) begin
            send_command(CMD_CLEAR, CHAR_W'($urandom), DELTA_W'($urandom),
                         RD_ROW_W'($urandom), RD_COL_W'($urandom));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) == 0) begin
                  send_command(CMD_W'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST)),
                               CHAR_W'($urandom), DELTA_W'($urandom),
                               RD_ROW_W'($urandom), RD_COL_W'($urandom));
               end else begin
                  send_command(CMD_W'($urandom_range(CMD_PUT, CMD_READ)),
                               CHAR_W'($urandom), DELTA_W'($urandom),
                               RD_ROW_W'($urandom), RD_COL_W'($urandom));
               end
            end
         end
      end
   endtask

   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      cursor_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reports_due.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("%0t: result beat with no command pending", $realtime);
            end
         end else begin
            want = reports_due.pop_front();
            if (rsp_cursor_row !== want.row || rsp_cursor_col !== want.col
                || rsp_cell_char !== want.cell_char || rsp_cell_attr !== want.cell_attr
                || rsp_scrolled !== want.scrolled) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("%0t: expected row %0d col %0d char %h attr %h scrolled %b",
                           $realtime, want.row, want.col, want.cell_char,
                           want.cell_attr, want.scrolled);
                  $display("%0t:      got row %0d col %0d char %h attr %h scrolled %b",
                           $realtime, rsp_cursor_row, rsp_cursor_col, rsp_cell_char,
                           rsp_cell_attr, rsp_scrolled);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cmd       <= CMD_PUT;
      req_char_code <= '0;
      req_row_delta <= '0;
      req_read_row  <= '0;
      req_read_col  <= '0;
      foreach (screen_mirror[i]) begin
         screen_mirror[i] = '0;
      end
      foreach (line_len[r]) begin
         line_len[r] = 0;
      end
      cursor_pos = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_output_backpressure();
      test_console_traffic(555, 27, 80);
      test_console_traffic(555, 80, 27);
      test_console_traffic(555, 0, 0);

      @(negedge clock);
      req_valid <= 1'b0;
      while (reports_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
